@@ hw/rtl/xrrd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrrd_pkg
// Types, constants and helpers shared by the random range draw block.
// ----------------------------------------------------------------------------
package xrrd_pkg;

    localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;
    localparam logic [63:0] RESET_WORD0 = 64'd1234567890;
    localparam logic [63:0] RESET_WORD1 = 64'd9876543210;
    localparam logic [63:0] PERCENT_TOP = 64'd100;
    localparam int          ROT_A       = 55;
    localparam int          SHIFT_B     = 14;
    localparam int          ROT_C       = 36;
    localparam int          MIX_SH0     = 30;
    localparam int          MIX_SH1     = 27;
    localparam int          MIX_SH2     = 31;

    typedef enum logic [1:0] {
        OP_RAW     = 2'd0,
        OP_RANGE   = 2'd1,
        OP_PERCENT = 2'd2,
        OP_CHANCE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MUL_P0 = 2'd0,
        MUL_P1 = 2'd1,
        MUL_P2 = 2'd2
    } t_mul_phase;

    typedef enum logic {
        SEED_IDLE = 1'b0,
        SEED_MUL  = 1'b1
    } t_seed_state;

    typedef enum logic [1:0] {
        BACK_IDLE = 2'd0,
        BACK_DIV  = 2'd1,
        BACK_SUM  = 2'd2,
        BACK_DONE = 2'd3
    } t_back_state;

    typedef struct packed {
        logic        valid;
        logic [63:0] word0;
        logic [63:0] word1;
    } t_load;

    typedef struct packed {
        logic        need_mod;
        logic        chance;
        logic [63:0] value;
        logic [63:0] span;
        logic [63:0] lo;
        logic [63:0] threshold;
    } t_job;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } t_fifo_ctl;

    function automatic logic [63:0] rotl(input logic [63:0] v, input int amount);
        rotl = (v << amount) | (v >> (64 - amount));
    endfunction

endpackage

@@ hw/rtl/xrrd_seed.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrrd_seed
// Reseed sequencer: two splitmix64 finalisers on a shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module xrrd_seed
    import xrrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic [63:0] i_wdata,
    output logic        o_busy,
    output t_load       o_load
);

    t_seed_state r_state, n_state;
    t_mul_phase  r_ph;
    logic        r_mul_b;
    logic        r_pass;
    logic [63:0] r_z;
    logic [63:0] r_acc;
    logic [63:0] r_w0;
    logic [63:0] w_k;
    logic [31:0] w_opa;
    logic [31:0] w_opb;
    logic [63:0] w_prod;
    logic [63:0] w_res;
    logic [63:0] w_fin;
    logic [63:0] w_w0;
    logic [63:0] w_seed;
    logic        w_last;

    assign w_k    = r_mul_b ? MIX_MUL_B : MIX_MUL_A;
    assign w_seed = i_wdata + GOLDEN_STEP;
    assign w_res  = r_acc + (w_prod << 32);
    assign w_fin  = w_res ^ (w_res >> MIX_SH2);
    assign w_w0   = w_fin + GOLDEN_STEP;
    assign w_last = (r_state == SEED_MUL) && (r_ph == MUL_P2) && r_mul_b && r_pass;

    always_comb begin
        unique case (r_ph)
            MUL_P0:  begin w_opa = r_z[31:0];  w_opb = w_k[31:0];  end
            MUL_P1:  begin w_opa = r_z[31:0];  w_opb = w_k[63:32]; end
            default: begin w_opa = r_z[63:32]; w_opb = w_k[31:0];  end
        endcase
    end

    assign w_prod = {32'd0, w_opa} * {32'd0, w_opb};

    always_comb begin
        n_state = r_state;
        if (i_we) begin
            n_state = SEED_MUL;
        end else if (w_last) begin
            n_state = SEED_IDLE;
        end
    end

    always_comb begin
        o_busy       = (r_state == SEED_MUL);
        o_load.valid = w_last && !i_we;
        o_load.word0 = r_w0;
        o_load.word1 = w_fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEED_IDLE;
            r_ph    <= MUL_P0;
            r_mul_b <= 1'b0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_we) begin
                r_ph    <= MUL_P0;
                r_mul_b <= 1'b0;
                r_pass  <= 1'b0;
            end else if (r_state == SEED_MUL) begin
                unique case (r_ph)
                    MUL_P0:  r_ph <= MUL_P1;
                    MUL_P1:  r_ph <= MUL_P2;
                    default: begin
                        r_ph    <= MUL_P0;
                        r_mul_b <= !r_mul_b;
                        if (r_mul_b) begin
                            r_pass <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_z <= w_seed ^ (w_seed >> MIX_SH0);
        end else if (r_state == SEED_MUL) begin
            unique case (r_ph)
                MUL_P0:  r_acc <= w_prod;
                MUL_P1:  r_acc <= r_acc + (w_prod << 32);
                default: begin
                    if (!r_mul_b) begin
                        r_z <= w_res ^ (w_res >> MIX_SH1);
                    end else if (!r_pass) begin
                        r_w0 <= w_w0;
                        r_z  <= w_w0 ^ (w_w0 >> MIX_SH0);
                    end
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/xrrd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrrd_fifo
// Two-entry job queue between the classifying front and the reducing back.
// ----------------------------------------------------------------------------
module xrrd_fifo
    import xrrd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_fifo_ctl i_ctl,
    input  t_job      i_job,
    output t_job      o_job,
    output logic      o_full,
    output logic      o_empty
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_wr    = i_ctl.push && !o_full;
    assign w_rd    = i_ctl.pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

@@ hw/rtl/xrrd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrrd_front
// Generator state, bound classification and job building per transaction.
// ----------------------------------------------------------------------------
module xrrd_front
    import xrrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_first_operand,
    input  logic [63:0] i_second_operand,
    input  t_load       i_load,
    output t_job        o_job
);

    logic [63:0] r_w0;
    logic [63:0] r_w1;
    logic [63:0] w_a;
    logic [63:0] w_b;
    logic [63:0] w_lo;
    logic [63:0] w_hi;
    logic [63:0] w_span;
    logic [63:0] w_sum;
    logic [63:0] w_x;
    logic        w_eq;
    logic        w_raw;

    always_comb begin
        w_raw = 1'b0;
        unique case (t_op'(i_operation))
            OP_RAW:     begin w_a = 64'd0; w_b = 64'd0; w_raw = 1'b1; end
            OP_RANGE:   begin w_a = i_first_operand; w_b = i_second_operand; end
            OP_PERCENT: begin w_a = 64'd1; w_b = PERCENT_TOP; end
            default:    begin w_a = 64'd1; w_b = i_second_operand; end
        endcase
    end

    assign w_lo   = (w_a > w_b) ? w_b : w_a;
    assign w_hi   = (w_a > w_b) ? w_a : w_b;
    assign w_eq   = !w_raw && (w_lo == w_hi);
    assign w_span = (w_hi + 64'd1) - w_lo;
    assign w_sum  = r_w0 + r_w1;
    assign w_x    = r_w1 ^ r_w0;

    always_comb begin
        o_job.chance    = (i_operation == OP_PERCENT) || (i_operation == OP_CHANCE);
        o_job.threshold = i_first_operand;
        o_job.lo        = w_lo;
        o_job.span      = w_span;
        o_job.value     = w_eq ? w_lo : w_sum;
        o_job.need_mod  = !w_raw && !w_eq && (w_span != 64'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0 <= RESET_WORD0;
            r_w1 <= RESET_WORD1;
        end else if (i_load.valid) begin
            r_w0 <= i_load.word0;
            r_w1 <= i_load.word1;
        end else if (i_accept && !w_eq) begin
            r_w0 <= rotl(r_w0, ROT_A) ^ w_x ^ (w_x << SHIFT_B);
            r_w1 <= rotl(w_x, ROT_C);
        end
    end

endmodule

@@ hw/rtl/xrrd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrrd_back
// Bit-serial modulo reduction, offset, chance compare and result register.
// ----------------------------------------------------------------------------
module xrrd_back
    import xrrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  logic        i_job_empty,
    output logic        o_job_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [63:0] o_drawn_value,
    output logic        o_chance_hit
);

    t_back_state r_state, n_state;
    t_job        r_job;
    logic [63:0] r_rem;
    logic [63:0] r_dvd;
    logic [5:0]  r_cnt;
    logic [63:0] r_val;
    logic        r_out_valid;
    logic [63:0] r_out_val;
    logic        r_out_hit;
    logic [64:0] w_t;
    logic [64:0] w_d;
    logic        w_out_free;

    assign w_t        = {r_rem, r_dvd[63]};
    assign w_d        = w_t - {1'b0, r_job.span};
    assign w_out_free = !r_out_valid || i_pop;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BACK_IDLE: begin
                if (!i_job_empty) begin
                    n_state = i_job.need_mod ? BACK_DIV : BACK_DONE;
                end
            end
            BACK_DIV:  if (r_cnt == 6'd63) n_state = BACK_SUM;
            BACK_SUM:  n_state = BACK_DONE;
            default:   if (w_out_free) n_state = BACK_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop = (r_state == BACK_IDLE) && !i_job_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BACK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == BACK_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BACK_IDLE: begin
                r_job <= i_job;
                r_val <= i_job.value;
                r_dvd <= i_job.value;
                r_rem <= 64'd0;
                r_cnt <= 6'd0;
            end
            BACK_DIV: begin
                r_rem <= w_d[64] ? w_t[63:0] : w_d[63:0];
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt + 6'd1;
            end
            BACK_SUM: r_val <= r_rem + r_job.lo;
            default: begin
                if (w_out_free) begin
                    r_out_val <= r_val;
                    r_out_hit <= r_job.chance && (r_val <= r_job.threshold);
                end
            end
        endcase
    end

    assign o_empty       = !r_out_valid;
    assign o_drawn_value = r_out_val;
    assign o_chance_hit  = r_out_hit;

endmodule

@@ hw/rtl/xoroshiro_random_range_draw.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xoroshiro_random_range_draw
// xoroshiro128+ draws: raw, range, percent and num-out-of chance.
//
// Input queue side: push/full carries one draw request per transaction.
// Result queue side: empty/pop; the oldest result sits on o_drawn_value and
// o_chance_hit while empty is low.
// The generator advances in the front when a request other than an
// equal-bound one is taken; a two-entry job queue feeds the back, which
// reduces by a restoring modulo at one bit a cycle. A raw, equal-bound or
// full-range request goes from the job queue through the back's job register
// to the result register; a reduced draw first runs the 64-step modulo loop.
// Up to two requests queue behind the one in the back.
// A seed write starts a reseed (two splitmix64 finalisers, each two
// 64-bit multiplies as three 32x32 products); full is high meanwhile.
// Reset loads the fixed generator words and empties all queues. If pop stays
// low the result is held and requests back up until full rises.
// ----------------------------------------------------------------------------
module xoroshiro_random_range_draw
    import xrrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_first_operand,
    input  logic [63:0] i_second_operand,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_drawn_value,
    output logic        o_chance_hit,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata
);

    t_load     w_load;
    t_job      w_job_in;
    t_job      w_job_out;
    t_fifo_ctl w_ctl;
    logic      w_busy;
    logic      w_qfull;
    logic      w_qempty;
    logic      w_qpop;
    logic      w_accept;

    assign full     = w_busy || w_qfull;
    assign w_accept = push && !full;

    always_comb begin
        w_ctl.push  = w_accept;
        w_ctl.pop   = w_qpop;
        w_ctl.full  = w_qfull;
        w_ctl.empty = w_qempty;
    end

    xrrd_seed u_seed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_wdata (i_cfg_wdata),
        .o_busy  (w_busy),
        .o_load  (w_load)
    );

    xrrd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_operation      (i_operation),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .i_load           (w_load),
        .o_job            (w_job_in)
    );

    xrrd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_job   (w_job_in),
        .o_job   (w_job_out),
        .o_full  (w_qfull),
        .o_empty (w_qempty)
    );

    xrrd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (w_job_out),
        .i_job_empty   (w_qempty),
        .o_job_pop     (w_qpop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_drawn_value (o_drawn_value),
        .o_chance_hit  (o_chance_hit)
    );

    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> full)
        else $error("reseed in progress without full");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load.valid |-> $past(w_busy))
        else $error("generator load outside a reseed");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_drawn_value)))
        else $error("waiting result lost or changed");

endmodule
